// File: rtl/core/tacb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command codes and the controller-to-datapath command type.
package tacb_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int ROW_W           = 48;
    localparam int CFG_IDX_W       = 2;
    localparam int AREA_W          = 53;
    localparam int SUM_W           = 64;

    localparam logic [47:0] ROW_X_RESET = 48'd4096;
    localparam logic [47:0] ROW_Y_RESET = 48'd268435456;
    localparam logic [47:0] ROW_Z_RESET = 48'd17592186044416;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_XFORM  = 3'd2;
    localparam logic [2:0] OP_CROSS  = 3'd3;
    localparam logic [2:0] OP_SQUARE = 3'd4;
    localparam logic [2:0] OP_SQRT   = 3'd5;
    localparam logic [2:0] OP_COMMIT = 3'd6;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] term;
        logic [1:0] comp;
        logic       esel;
    } cmd_t;

endpackage

// File: rtl/core/tacb_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps the datapath through transform, cross product, squares and root.
module tacb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output tacb_pkg::cmd_t    cmd
);
    import tacb_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_XFORM  = 4'd1;
    localparam logic [3:0] ST_XDRAIN = 4'd2;
    localparam logic [3:0] ST_CROSS  = 4'd3;
    localparam logic [3:0] ST_CDRAIN = 4'd4;
    localparam logic [3:0] ST_SQUARE = 4'd5;
    localparam logic [3:0] ST_SDRAIN = 4'd6;
    localparam logic [3:0] ST_SQRT   = 4'd7;
    localparam logic [3:0] ST_WRITE  = 4'd8;

    localparam logic [5:0] SQRT_LAST = 6'd51;

    logic [3:0] state_reg, state_next;
    logic [1:0] term_reg, term_next;
    logic [1:0] comp_reg, comp_next;
    logic       esel_reg, esel_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        comp_next      = comp_reg;
        esel_next      = esel_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd.op         = OP_NONE;
        cmd.term       = term_reg;
        cmd.comp       = comp_reg;
        cmd.esel       = esel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                term_next = 2'd0;
                comp_next = 2'd0;
                esel_next = 1'b0;
                cnt_next  = 6'd0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_XFORM;
                end
            end
            ST_XFORM:
            begin
                cmd.op = OP_XFORM;
                if (term_reg == 2'd2)
                begin
                    term_next = 2'd0;
                    if (comp_reg == 2'd2)
                    begin
                        comp_next = 2'd0;
                        esel_next = ~esel_reg;
                        if (esel_reg)
                            state_next = ST_XDRAIN;
                    end
                    else
                        comp_next = comp_reg + 2'd1;
                end
                else
                    term_next = term_reg + 2'd1;
            end
            ST_XDRAIN:
                state_next = ST_CROSS;
            ST_CROSS:
            begin
                cmd.op = OP_CROSS;
                if (term_reg == 2'd1)
                begin
                    term_next = 2'd0;
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = 2'd0;
                        state_next = ST_CDRAIN;
                    end
                    else
                        comp_next = comp_reg + 2'd1;
                end
                else
                    term_next = term_reg + 2'd1;
            end
            ST_CDRAIN:
                state_next = ST_SQUARE;
            ST_SQUARE:
            begin
                cmd.op = OP_SQUARE;
                if (term_reg == 2'd2)
                begin
                    term_next = 2'd0;
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = 2'd0;
                        state_next = ST_SDRAIN;
                    end
                    else
                        comp_next = comp_reg + 2'd1;
                end
                else
                    term_next = term_reg + 2'd1;
            end
            ST_SDRAIN:
                state_next = ST_SQRT;
            ST_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // The result register must be free before the next result lands in it.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            term_reg      <= 2'd0;
            comp_reg      <= 2'd0;
            esel_reg      <= 1'b0;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            comp_reg      <= comp_next;
            esel_reg      <= esel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/tacb_dp.sv
`timescale 1ns / 1ps
// Datapath: edge capture, shared multiplier, accumulators, bitwise square root and running sum.
module tacb_dp #(
    parameter int COORD_WIDTH = tacb_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tacb_pkg::cmd_t                     cmd,
    input  logic signed [COORD_WIDTH-1:0]      a_x,
    input  logic signed [COORD_WIDTH-1:0]      a_y,
    input  logic signed [COORD_WIDTH-1:0]      a_z,
    input  logic signed [COORD_WIDTH-1:0]      b_x,
    input  logic signed [COORD_WIDTH-1:0]      b_y,
    input  logic signed [COORD_WIDTH-1:0]      b_z,
    input  logic signed [COORD_WIDTH-1:0]      c_x,
    input  logic signed [COORD_WIDTH-1:0]      c_y,
    input  logic signed [COORD_WIDTH-1:0]      c_z,
    input  logic                               mesh_start,
    input  logic                               cfg_we,
    input  logic [tacb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tacb_pkg::ROW_W-1:0]         cfg_data,
    output logic [tacb_pkg::AREA_W-1:0]        tri_area,
    output logic [tacb_pkg::SUM_W-1:0]         cum_area,
    output logic                               sum_saturated
);
    import tacb_pkg::*;

    localparam int EW  = COORD_WIDTH + 1;
    localparam int XSW = (EW + 18 > 52) ? EW + 18 : 52;
    localparam int RW  = XSW - 12;
    localparam int MW  = (EW > 27) ? EW : 27;

    logic [ROW_W-1:0]         row_reg [3];
    logic signed [EW-1:0]     e_reg [3];
    logic signed [EW-1:0]     f_reg [3];
    logic                     start_reg;
    logic signed [24:0]       u_reg [3];
    logic signed [24:0]       v_reg [3];
    logic [50:0]              mag_reg [3];
    logic signed [2*MW-1:0]   prod_reg;
    cmd_t                     cmdd_reg;
    logic signed [XSW-1:0]    acc_reg;
    logic [103:0]             s_reg;
    logic [55:0]              rem_reg;
    logic [51:0]              root_reg;
    logic [SUM_W-1:0]         running_reg;
    logic [AREA_W-1:0]        tri_area_reg;
    logic [SUM_W-1:0]         cum_area_reg;
    logic                     sat_reg;

    logic [ROW_W-1:0]         sel_row;
    logic signed [15:0]       sel_coef;
    logic signed [EW-1:0]     sel_edge;
    logic [50:0]              sel_mag;
    logic signed [MW-1:0]     op_a;
    logic signed [MW-1:0]     op_b;

    logic signed [XSW-1:0]    prod_x;
    logic signed [XSW-1:0]    xf_sum;
    logic signed [XSW-1:0]    xf_rnd;
    logic signed [RW-1:0]     xf_r;
    logic [RW-25:0]           xf_hi;
    logic signed [24:0]       xf_val;
    logic signed [51:0]       cr_n;
    logic [50:0]              cr_mag;
    logic [103:0]             sq_add;
    logic [55:0]              rt_rem;
    logic [55:0]              rt_trial;
    logic                     rt_ge;
    logic [SUM_W-1:0]         cm_base;
    logic [SUM_W:0]           cm_sum;

    assign tri_area      = tri_area_reg;
    assign cum_area      = cum_area_reg;
    assign sum_saturated = sat_reg;

    // Multiplier operand selection for the command issued this cycle.
    always_comb
    begin
        unique case (cmd.comp)
            2'd0:    sel_row = row_reg[0];
            2'd1:    sel_row = row_reg[1];
            default: sel_row = row_reg[2];
        endcase
        unique case (cmd.term)
            2'd0:
            begin
                sel_coef = sel_row[15:0];
                sel_edge = cmd.esel ? f_reg[0] : e_reg[0];
            end
            2'd1:
            begin
                sel_coef = sel_row[31:16];
                sel_edge = cmd.esel ? f_reg[1] : e_reg[1];
            end
            default:
            begin
                sel_coef = sel_row[47:32];
                sel_edge = cmd.esel ? f_reg[2] : e_reg[2];
            end
        endcase
        unique case (cmd.comp)
            2'd0:    sel_mag = mag_reg[0];
            2'd1:    sel_mag = mag_reg[1];
            default: sel_mag = mag_reg[2];
        endcase

        op_a = '0;
        op_b = '0;
        unique case (cmd.op)
            OP_XFORM:
            begin
                op_a = MW'(sel_coef);
                op_b = MW'(sel_edge);
            end
            OP_CROSS:
            begin
                unique case ({cmd.comp, cmd.term[0]})
                    3'b000:
                    begin
                        op_a = MW'(u_reg[1]);
                        op_b = MW'(v_reg[2]);
                    end
                    3'b001:
                    begin
                        op_a = MW'(u_reg[2]);
                        op_b = MW'(v_reg[1]);
                    end
                    3'b010:
                    begin
                        op_a = MW'(u_reg[2]);
                        op_b = MW'(v_reg[0]);
                    end
                    3'b011:
                    begin
                        op_a = MW'(u_reg[0]);
                        op_b = MW'(v_reg[2]);
                    end
                    3'b100:
                    begin
                        op_a = MW'(u_reg[0]);
                        op_b = MW'(v_reg[1]);
                    end
                    3'b101:
                    begin
                        op_a = MW'(u_reg[1]);
                        op_b = MW'(v_reg[0]);
                    end
                    default:
                    begin
                        op_a = '0;
                        op_b = '0;
                    end
                endcase
            end
            OP_SQUARE:
            begin
                // A magnitude splits into a 26-bit low part and a 25-bit high part.
                unique case (cmd.term)
                    2'd0:
                    begin
                        op_a[25:0] = sel_mag[25:0];
                        op_b[25:0] = sel_mag[25:0];
                    end
                    2'd1:
                    begin
                        op_a[25:0] = sel_mag[25:0];
                        op_b[24:0] = sel_mag[50:26];
                    end
                    default:
                    begin
                        op_a[24:0] = sel_mag[50:26];
                        op_b[24:0] = sel_mag[50:26];
                    end
                endcase
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Accumulation of the product registered in the cycle before.
    always_comb
    begin
        prod_x = prod_reg[XSW-1:0];
        xf_sum = ((cmdd_reg.term == 2'd0) ? '0 : acc_reg) + prod_x;
        xf_rnd = xf_sum + XSW'(2048);
        xf_r   = xf_rnd[XSW-1:12];
        xf_hi  = xf_r[RW-1:24];
        if ((&xf_hi) || (~|xf_hi))
            xf_val = xf_r[24:0];
        else if (xf_r[RW-1])
            xf_val = {1'b1, 24'd0};
        else
            xf_val = {1'b0, {24{1'b1}}};

        cr_n   = acc_reg[51:0] - prod_reg[51:0];
        cr_mag = cr_n[51] ? 51'(-cr_n) : cr_n[50:0];

        unique case (cmdd_reg.term)
            2'd0:    sq_add = 104'(prod_reg[51:0]);
            2'd1:    sq_add = 104'(prod_reg[51:0]) << 27;
            default: sq_add = 104'(prod_reg[51:0]) << 52;
        endcase

        rt_rem   = {rem_reg[53:0], s_reg[103:102]};
        rt_trial = {2'b00, root_reg, 2'b01};
        rt_ge    = (rt_rem >= rt_trial);

        cm_base = start_reg ? '0 : running_reg;
        cm_sum  = {1'b0, cm_base} + (SUM_W + 1)'(root_reg[51:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]  <= ROW_X_RESET;
            row_reg[1]  <= ROW_Y_RESET;
            row_reg[2]  <= ROW_Z_RESET;
            cmdd_reg    <= '0;
            running_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROW_X)
                    row_reg[0] <= cfg_data;
                else if (cfg_index == REG_ROW_Y)
                    row_reg[1] <= cfg_data;
                else if (cfg_index == REG_ROW_Z)
                    row_reg[2] <= cfg_data;
            end
            cmdd_reg <= cmd;
            if (cmd.op == OP_COMMIT)
                running_reg <= cm_sum[SUM_W] ? '1 : cm_sum[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;

        if (cmd.op == OP_LOAD)
        begin
            e_reg[0]  <= EW'(b_x) - EW'(a_x);
            e_reg[1]  <= EW'(b_y) - EW'(a_y);
            e_reg[2]  <= EW'(b_z) - EW'(a_z);
            f_reg[0]  <= EW'(c_x) - EW'(a_x);
            f_reg[1]  <= EW'(c_y) - EW'(a_y);
            f_reg[2]  <= EW'(c_z) - EW'(a_z);
            start_reg <= mesh_start;
            s_reg     <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else if (cmd.op == OP_SQRT)
        begin
            rem_reg  <= rt_ge ? (rt_rem - rt_trial) : rt_rem;
            root_reg <= {root_reg[50:0], rt_ge};
            s_reg    <= s_reg << 2;
        end
        else if (cmdd_reg.op == OP_SQUARE)
            s_reg <= s_reg + sq_add;

        if (cmdd_reg.op == OP_XFORM)
        begin
            acc_reg <= xf_sum;
            if (cmdd_reg.term == 2'd2)
            begin
                unique case ({cmdd_reg.esel, cmdd_reg.comp})
                    3'b000:  u_reg[0] <= xf_val;
                    3'b001:  u_reg[1] <= xf_val;
                    3'b010:  u_reg[2] <= xf_val;
                    3'b100:  v_reg[0] <= xf_val;
                    3'b101:  v_reg[1] <= xf_val;
                    3'b110:  v_reg[2] <= xf_val;
                    default: ;
                endcase
            end
        end
        else if (cmdd_reg.op == OP_CROSS)
        begin
            if (cmdd_reg.term == 2'd0)
                acc_reg <= prod_x;
            else
            begin
                unique case (cmdd_reg.comp)
                    2'd0:    mag_reg[0] <= cr_mag;
                    2'd1:    mag_reg[1] <= cr_mag;
                    default: mag_reg[2] <= cr_mag;
                endcase
            end
        end

        if (cmd.op == OP_COMMIT)
        begin
            tri_area_reg <= AREA_W'(root_reg[51:1]);
            cum_area_reg <= cm_sum[SUM_W] ? '1 : cm_sum[SUM_W-1:0];
            sat_reg      <= cm_sum[SUM_W];
        end
    end

endmodule

// File: rtl/core/triangle_area_cdf_builder.sv
`timescale 1ns / 1ps
// A triangle passes through 18 transform products, 6 cross-product terms and
// 9 partial squares on one shared multiplier, then 52 root steps, before its result.
// Only one triangle is in flight: a new one is taken only when the sequencer is
// idle. A new triangle is taken while the last result waits.
// Reset restores the identity transform and clears the running sum and all handshakes.
module triangle_area_cdf_builder #(
    parameter int COORD_WIDTH = tacb_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COORD_WIDTH-1:0]      a_x,
    input  logic signed [COORD_WIDTH-1:0]      a_y,
    input  logic signed [COORD_WIDTH-1:0]      a_z,
    input  logic signed [COORD_WIDTH-1:0]      b_x,
    input  logic signed [COORD_WIDTH-1:0]      b_y,
    input  logic signed [COORD_WIDTH-1:0]      b_z,
    input  logic signed [COORD_WIDTH-1:0]      c_x,
    input  logic signed [COORD_WIDTH-1:0]      c_y,
    input  logic signed [COORD_WIDTH-1:0]      c_z,
    input  logic                               mesh_start,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tacb_pkg::AREA_W-1:0]        tri_area,
    output logic [tacb_pkg::SUM_W-1:0]         cum_area,
    output logic                               sum_saturated,
    input  logic                               cfg_we,
    input  logic [tacb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tacb_pkg::ROW_W-1:0]         cfg_data
);
    import tacb_pkg::*;

    cmd_t cmd;

    tacb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tacb_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .a_x           (a_x),
        .a_y           (a_y),
        .a_z           (a_z),
        .b_x           (b_x),
        .b_y           (b_y),
        .b_z           (b_z),
        .c_x           (c_x),
        .c_y           (c_y),
        .c_z           (c_z),
        .mesh_start    (mesh_start),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .tri_area      (tri_area),
        .cum_area      (cum_area),
        .sum_saturated (sum_saturated)
    );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the triangle area and cumulative area builder.
module tb_top;
    import tacb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CW         = COORD_WIDTH_DEF;
    localparam int WATCH_MAX  = 4000;
    localparam int DRAIN_WAIT = 120;
    localparam int PHASE_ITEMS = 125;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE  = 4096;

    typedef struct {
        logic signed [CW-1:0] p [9];
        logic                 start;
    } tri_t;

    typedef struct {
        bit                 typed;
        logic [AREA_W-1:0]  area;
        logic [SUM_W-1:0]   cum;
    } tri_hint_t;

    typedef struct {
        logic [AREA_W-1:0]  area;
        logic [SUM_W-1:0]   cum;
        logic               sat;
    } area_rec_t;

    typedef struct {
        tri_t      t;
        tri_hint_t h;
    } stim_row_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic mesh_start;
    logic [AREA_W-1:0] tri_area;
    logic [SUM_W-1:0]  cum_area;
    logic sum_saturated;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0] cfg_data;

    logic [ROW_W-1:0] row_x, row_y, row_z;
    logic [SUM_W-1:0] running_sum;
    area_rec_t expected_areas [$];
    tri_hint_t hint_q [$];
    int  mismatches;
    bit  quiet;
    int  hold_request;
    stim_row_t dir_rows [13];

    triangle_area_cdf_builder uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .mesh_start(mesh_start),
        .out_valid(out_valid), .out_ready(out_ready),
        .tri_area(tri_area), .cum_area(cum_area), .sum_saturated(sum_saturated),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // One world-space component: Q.24 dot product rounded half up to Q.12, then clamped.
    function automatic longint world_comp(logic [ROW_W-1:0] row, longint ex, longint ey,
                                          longint ez);
        longint s;
        longint r;
        s = longint'($signed(row[15:0])) * ex + longint'($signed(row[31:16])) * ey
            + longint'($signed(row[47:32])) * ez;
        r = (s + 2048) >>> 12;
        if (r > 64'sd16777215) r = 64'sd16777215;
        if (r < -64'sd16777216) r = -64'sd16777216;
        return r;
    endfunction

    function automatic logic [AREA_W-1:0] tri_area_of(tri_t t);
        longint e [6];
        longint u [3];
        longint v [3];
        longint n [3];
        logic [127:0] sq;
        logic [127:0] m;
        logic [127:0] root;
        logic [127:0] cand;
        for (int i = 0; i < 3; i++)
        begin
            e[i]     = longint'(t.p[3+i]) - longint'(t.p[i]);
            e[3+i]   = longint'(t.p[6+i]) - longint'(t.p[i]);
        end
        u[0] = world_comp(row_x, e[0], e[1], e[2]);
        u[1] = world_comp(row_y, e[0], e[1], e[2]);
        u[2] = world_comp(row_z, e[0], e[1], e[2]);
        v[0] = world_comp(row_x, e[3], e[4], e[5]);
        v[1] = world_comp(row_y, e[3], e[4], e[5]);
        v[2] = world_comp(row_z, e[3], e[4], e[5]);
        n[0] = u[1] * v[2] - u[2] * v[1];
        n[1] = u[2] * v[0] - u[0] * v[2];
        n[2] = u[0] * v[1] - u[1] * v[0];
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            m  = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
            sq = sq + m * m;
        end
        root = '0;
        for (int b = 51; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sq) root = cand;
        end
        return AREA_W'(root >> 1);
    endfunction

    always @(posedge clk)
    begin : scoreboard
        tri_t      t;
        tri_hint_t h;
        area_rec_t want;
        area_rec_t got;
        logic [SUM_W:0] total;
        logic [SUM_W-1:0] base;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW_X: row_x = cfg_data;
                    REG_ROW_Y: row_y = cfg_data;
                    REG_ROW_Z: row_z = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got.area = tri_area;
                got.cum  = cum_area;
                got.sat  = sum_saturated;
                if (expected_areas.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: area %0d cum %0d sat %0d",
                                 got.area, got.cum, got.sat);
                end
                else
                begin
                    want = expected_areas.pop_front();
                    if (got.area !== want.area || got.cum !== want.cum
                        || got.sat !== want.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: area exp %0d got %0d, cum exp %0d got %0d, sat exp %0d got %0d",
                                     want.area, got.area, want.cum, got.cum,
                                     want.sat, got.sat);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                t.p = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
                t.start = mesh_start;
                h = hint_q.pop_front();
                base = t.start ? '0 : running_sum;
                want.area = tri_area_of(t);
                total = {1'b0, base} + want.area;
                want.sat = total[SUM_W];
                want.cum = want.sat ? '1 : total[SUM_W-1:0];
                if (h.typed)
                begin
                    want.area = h.area;
                    want.cum  = h.cum;
                    want.sat  = 1'b0;
                end
                running_sum = want.cum;
                expected_areas.insert(expected_areas.size(), want);
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin : result_sink
        int hold_left;
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (!quiet && $urandom_range(99) < 24) ? 1'b0 : 1'b1;
    end

    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_MAX)
        begin
            $display("triangle_area_cdf_builder test failed");
            $finish;
        end
    end

    task automatic send_tri(tri_t t, tri_hint_t h);
        while (!quiet && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        hint_q.insert(hint_q.size(), h);
        {a_x, a_y, a_z} <= {t.p[0], t.p[1], t.p[2]};
        {b_x, b_y, b_z} <= {t.p[3], t.p[4], t.p[5]};
        {c_x, c_y, c_z} <= {t.p[6], t.p[7], t.p[8]};
        mesh_start <= t.start;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_areas.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        return CW'($urandom);
    endfunction

    function automatic tri_t rand_tri();
        tri_t t;
        int   mode;
        int   k;
        logic signed [CW-1:0] d [3];
        mode = $urandom_range(9);
        for (int i = 0; i < 9; i++)
            t.p[i] = rand_coord();
        if (mode >= 5 && mode <= 6)
        begin
            // Small triangles around a random point keep areas near typical meshes.
            for (int i = 0; i < 3; i++)
            begin
                t.p[i] = CW'($signed(CW'($urandom_range(2 ** 21))) - (2 ** 20));
                t.p[3+i] = CW'(t.p[i] + $signed(CW'($urandom_range(2 ** 15))) - (2 ** 14));
                t.p[6+i] = CW'(t.p[i] + $signed(CW'($urandom_range(2 ** 15))) - (2 ** 14));
            end
        end
        else if (mode == 7)
        begin
            k = $urandom_range(6) - 3;
            for (int i = 0; i < 3; i++)
            begin
                t.p[i]   = CW'($signed(CW'($urandom_range(2 ** 21))) - (2 ** 20));
                d[i]     = CW'($signed(CW'($urandom_range(2 ** 13))) - (2 ** 12));
                t.p[3+i] = t.p[i] + d[i];
                t.p[6+i] = CW'(t.p[i] + k * d[i]);
            end
        end
        else if (mode == 8)
        begin
            for (int i = 3; i < 9; i++)
                t.p[i] = t.p[i % 3];
        end
        else if (mode == 9)
        begin
            for (int i = 0; i < 9; i++)
                t.p[i] = $urandom_range(1) ? CMAX - CW'($urandom_range(3))
                                           : CMIN + CW'($urandom_range(3));
        end
        t.start = ($urandom_range(7) == 0);
        return t;
    endfunction

    function automatic logic [ROW_W-1:0] fill_row(logic [15:0] c);
        return {c, c, c};
    endfunction

    function automatic stim_row_t mk_row(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                         logic signed [CW-1:0] az, logic signed [CW-1:0] bx,
                                         logic signed [CW-1:0] by, logic signed [CW-1:0] bz,
                                         logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                         logic signed [CW-1:0] cz, logic st, bit typed,
                                         logic [AREA_W-1:0] area, logic [SUM_W-1:0] cum);
        stim_row_t r;
        r.t.p = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        r.t.start = st;
        r.h.typed = typed;
        r.h.area = area;
        r.h.cum = cum;
        return r;
    endfunction

    initial
    begin : stimulus
        tri_hint_t none;
        none = '{typed: 1'b0, area: '0, cum: '0};
        row_x = ROW_X_RESET;
        row_y = ROW_Y_RESET;
        row_z = ROW_Z_RESET;
        running_sum = '0;
        mismatches = 0;
        quiet = 1'b0;
        hold_request = 0;
        rst_n = 1'b0;
        in_valid <= 1'b0;
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <= '0;
        mesh_start <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_ROW_X;
        cfg_data <= '0;

        // Reset transform is the identity; unit right triangles have area one half.
        dir_rows[0]  = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        dir_rows[1]  = mk_row(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 1, 53'd8388608, 64'd8388608);
        dir_rows[2]  = mk_row(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 1, 53'd8388608, 64'd16777216);
        dir_rows[3]  = mk_row(0, 0, 0, 0, ONE, 0, 0, 0, ONE, 1, 1, 53'd8388608, 64'd8388608);
        dir_rows[4]  = mk_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, 0,
                              0, 0, 0);
        dir_rows[5]  = mk_row(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, 0,
                              0, 0, 0);
        dir_rows[6]  = mk_row(CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, 0,
                              0, 0, 0);
        // Collinear and coincident vertices are degenerate.
        dir_rows[7]  = mk_row(100, 200, 300, 200, 400, 600, 300, 600, 900, 1, 1, 0, 0);
        dir_rows[8]  = mk_row(CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, 1,
                              1, 0, 0);
        dir_rows[9]  = mk_row(-ONE, -ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE, ONE, 0, 0, 0, 0);
        dir_rows[10] = mk_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1,
                              1, 0, 0);
        dir_rows[11] = mk_row(1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0);
        dir_rows[12] = mk_row(CMAX, 0, CMIN, 0, CMAX, 0, CMIN, CMIN, CMAX, 1, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_tri(dir_rows[i].t, dir_rows[i].h);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_ROW_X, ROW_W'({$urandom, $urandom}));
                    write_reg(REG_ROW_Y, ROW_W'({$urandom, $urandom}));
                    write_reg(REG_ROW_Z, ROW_W'({$urandom, $urandom}));
                end
                1:
                begin
                    write_reg(REG_ROW_X, fill_row(16'h7fff));
                    write_reg(REG_ROW_Y, fill_row(16'h7fff));
                    write_reg(REG_ROW_Z, fill_row(16'h7fff));
                end
                2:
                begin
                    write_reg(REG_ROW_X, fill_row(16'h8000));
                    write_reg(REG_ROW_Y, fill_row(16'h8000));
                    write_reg(REG_ROW_Z, fill_row(16'h8000));
                end
                3:
                begin
                    write_reg(REG_ROW_X, '0);
                    write_reg(REG_ROW_Y, {32'h0, 16'hffff});
                    write_reg(REG_ROW_Z, '1);
                end
                4:
                begin
                    write_reg(REG_ROW_X, ROW_W'({$urandom, $urandom}));
                    write_reg(REG_ROW_Y, {16'h0, 16'h1000, 16'h0});
                    write_reg(REG_ROW_Z, ROW_W'({$urandom, $urandom}));
                    write_reg(REG_UNUSED, ROW_W'({$urandom, $urandom}));
                end
                default:
                begin
                    write_reg(REG_ROW_X, ROW_X_RESET);
                    write_reg(REG_ROW_Y, ROW_Y_RESET);
                    write_reg(REG_ROW_Z, ROW_Z_RESET);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 1 && n == 60)
                begin
                    // The sender waits here until every result has come back.
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (expected_areas.size() != 0) @(posedge clk);
                end
                if (ph == 2 && n == 10)
                    hold_request = 600;
                if (ph == 3)
                    quiet = (n >= 20 && n < 100);
                send_tri(rand_tri(), none);
            end
            quiet = 1'b0;
            drain();
        end

        if (mismatches == 0 && expected_areas.size() == 0)
            $display("triangle_area_cdf_builder test passed");
        else
            $display("triangle_area_cdf_builder test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/tacb_pkg.sv
rtl/core/tacb_ctrl.sv
rtl/core/tacb_dp.sv
rtl/core/triangle_area_cdf_builder.sv
test/tb_top.sv
